FILE: src/cbrf_pkg.sv
// Shared types and constants for the cubic bisection root finder.
package cbrf_pkg;

    localparam int MAX_STEPS_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int MAX_DECIMALS      = 5;

    typedef enum logic [1:0] {
        ST_CONVERGED  = 2'd0,
        ST_EXACT_ROOT = 2'd1,
        ST_BAD_RANGE  = 2'd2,
        ST_CAP_HIT    = 2'd3
    } result_status_t;

    localparam logic [2:0] REG_DECIMALS = 3'd0;
    localparam logic [2:0] REG_CUBIC    = 3'd1;
    localparam logic [2:0] REG_SQUARE   = 3'd2;
    localparam logic [2:0] REG_LINEAR   = 3'd3;
    localparam logic [2:0] REG_CONSTANT = 3'd4;

    // Powers of ten up to ten to the fifth, indexed by the clamped digit count.
    function automatic logic [16:0] ten_power(input logic [2:0] d);
        logic [16:0] p;
        begin
            case (d)
                3'd0:    p = 17'd1;
                3'd1:    p = 17'd10;
                3'd2:    p = 17'd100;
                3'd3:    p = 17'd1000;
                3'd4:    p = 17'd10000;
                default: p = 17'd100000;
            endcase
            return p;
        end
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the interval ends, clear step state
        logic eval_start; // start a cubic evaluation
        logic eval_sel;   // 0: lower end, 1: upper end, ignored when eval_mid
        logic eval_mid;   // evaluate at the midpoint
        logic save_low;   // keep f(lower) sign
        logic make_mid;   // form midpoint and its decimal image
        logic step;       // replace one end, count a step
        logic finish;     // latch result with given status
        result_status_t fin_status;
    } cbrf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic eval_done;
        logic f_zero;
        logic f_neg;
        logic bad_range;   // f(lower), f(upper) not strictly opposite
        logic image_same;  // decimal image equals previous one
        logic cap_hit;
    } cbrf_stat_t;

endpackage

FILE: src/cbrf_if.sv
// Valid/ready channel interfaces for the root finder.
interface cbrf_in_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] lower_end;
    logic signed [31:0] upper_end;
    modport source (output valid, lower_end, upper_end, input ready);
    modport sink   (input valid, lower_end, upper_end, output ready);
endinterface

interface cbrf_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] root_value;
    logic signed [32:0] root_rounded_scaled;
    logic [6:0]  iterations_used;
    modport source (output valid, status, root_value, root_rounded_scaled,
                    iterations_used, input ready);
    modport sink   (input valid, status, root_value, root_rounded_scaled,
                    iterations_used, output ready);
endinterface

FILE: src/cbrf_horner.sv
// Multi-cycle Horner evaluator on a 32x32 multiplier with saturating products.
module cbrf_horner
    import cbrf_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] x,
    input  logic signed [31:0] c3,
    input  logic signed [31:0] c2,
    input  logic signed [31:0] c1,
    input  logic signed [31:0] c0,
    output logic               done,
    output logic signed [63:0] f
);
    localparam int SH = 32 - FRACTION_BITS;

    typedef enum logic [3:0] {
        H_IDLE = 4'b0001,
        H_MULL = 4'b0010,
        H_MULH = 4'b0100,
        H_ADD  = 4'b1000
    } hstate_t;

    hstate_t state_reg, state_next;
    logic [1:0]  round_reg, round_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] x_reg;
    logic        neg_reg;
    logic [63:0] lo_reg, hi_reg;
    logic        done_reg, done_next;

    logic [63:0] acc_mag;
    logic [31:0] x_mag;
    logic [63:0] limit;
    logic [63:0] lo_sh;
    logic [63:0] r_val;
    logic        ovf;
    logic signed [63:0] prod;
    logic signed [31:0] coef;
    logic signed [64:0] sum65;
    logic signed [63:0] sum_sat;
    logic [63:0] mul_in;
    logic [63:0] part_prod;

    assign acc_mag = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign x_mag   = x_reg[31] ? (32'd0 - x_reg) : x_reg;
    assign mul_in  = (state_reg == H_MULL) ? {32'd0, acc_mag[31:0]} : {32'd0, acc_mag[63:32]};
    assign part_prod = mul_in * {32'd0, x_mag};
    assign limit   = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    assign lo_sh   = lo_reg >> FRACTION_BITS;

    always_comb
    begin
        ovf   = (hi_reg > (limit >> SH));
        r_val = hi_reg << SH;
        if (!ovf && (r_val > (limit - lo_sh)))
        begin
            ovf = 1'b1;
        end
        r_val = r_val + lo_sh;
        if (ovf)
        begin
            prod = neg_reg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else if (neg_reg)
        begin
            prod = 64'd0 - r_val;
        end
        else
        begin
            prod = r_val;
        end
    end

    always_comb
    begin
        case (round_reg)
            2'd0:    coef = c2;
            2'd1:    coef = c1;
            default: coef = c0;
        endcase
        sum65 = {prod[63], prod} + 65'(coef);
        if (sum65[64] != sum65[63])
        begin
            sum_sat = sum65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            sum_sat = sum65[63:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    acc_next   = 64'(c3);
                    round_next = 2'd0;
                    state_next = H_MULL;
                end
            end
            H_MULL: state_next = H_MULH;
            H_MULH: state_next = H_ADD;
            H_ADD:
            begin
                acc_next = sum_sat;
                if (round_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
                else
                begin
                    round_next = round_reg + 2'd1;
                    state_next = H_MULL;
                end
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done_reg  <= 1'b0;
            round_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start && state_reg == H_IDLE)
        begin
            x_reg   <= x;
            neg_reg <= (c3 < 0) != (x < 0);
        end
        else if (state_reg == H_ADD)
        begin
            neg_reg <= (sum_sat < 0) != (x_reg < 0);
        end
        if (state_reg == H_MULL)
        begin
            lo_reg <= part_prod;
        end
        if (state_reg == H_MULH)
        begin
            hi_reg <= part_prod;
        end
    end

    assign done = done_reg;
    assign f    = acc_reg;
endmodule

FILE: src/cbrf_datapath.sv
// Datapath: interval registers, midpoint, decimal image and result register.
module cbrf_datapath
    import cbrf_pkg::*;
#(
    parameter int MAX_STEPS     = MAX_STEPS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cbrf_cmd_t          cmd,
    output cbrf_stat_t         stat,
    input  logic signed [31:0] lower_in,
    input  logic signed [31:0] upper_in,
    input  logic [2:0]         decimals,
    input  logic signed [31:0] c3,
    input  logic signed [31:0] c2,
    input  logic signed [31:0] c1,
    input  logic signed [31:0] c0,
    output logic [1:0]         res_status,
    output logic signed [31:0] res_root,
    output logic signed [32:0] res_scaled,
    output logic [6:0]         res_iters
);
    logic signed [31:0] low_end_reg, high_end_reg, midpoint_reg;
    logic [32:0] previous_rounded_reg, current_rounded_reg;
    logic        low_end_sign_reg, low_zero_reg;
    logic [6:0]  step_count_reg;
    logic [48:0] scaled_reg;
    logic        mid_neg_reg;
    logic        img_phase_reg;

    logic signed [32:0] sum33;
    logic signed [31:0] mid_val;
    logic [31:0] mid_mag;
    logic [2:0]  d_clamp;
    logic [48:0] rounded;
    logic [32:0] img;
    logic signed [31:0] eval_x;
    logic signed [63:0] f_val;
    logic        f_done;

    assign sum33   = 33'(low_end_reg) + 33'(high_end_reg);
    assign mid_val = sum33[32:1];
    assign mid_mag = midpoint_reg[31] ? (32'd0 - midpoint_reg) : midpoint_reg;
    assign d_clamp = (decimals > 3'(MAX_DECIMALS)) ? 3'(MAX_DECIMALS) : decimals;
    assign rounded = (scaled_reg + (49'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    assign img     = mid_neg_reg ? (33'd0 - rounded[32:0]) : rounded[32:0];
    assign eval_x  = cmd.eval_mid ? midpoint_reg : (cmd.eval_sel ? high_end_reg : low_end_reg);

    cbrf_horner #(.FRACTION_BITS(FRACTION_BITS)) u_horner (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.eval_start),
        .x     (eval_x),
        .c3    (c3),
        .c2    (c2),
        .c1    (c1),
        .c0    (c0),
        .done  (f_done),
        .f     (f_val)
    );

    assign stat.eval_done  = f_done;
    assign stat.f_zero     = (f_val == 64'sd0);
    assign stat.f_neg      = f_val[63];
    assign stat.bad_range  = low_zero_reg || (f_val == 64'sd0) || (low_end_sign_reg == f_val[63]);
    assign stat.image_same = (current_rounded_reg == previous_rounded_reg);
    assign stat.cap_hit    = (32'(step_count_reg) >= 32'(MAX_STEPS));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            low_end_reg          <= lower_in;
            high_end_reg         <= upper_in;
            previous_rounded_reg <= 33'd0;
            step_count_reg       <= 7'd0;
        end
        if (cmd.save_low)
        begin
            low_end_sign_reg <= f_val[63];
            low_zero_reg     <= (f_val == 64'sd0);
        end
        if (cmd.step)
        begin
            if (f_val[63] == low_end_sign_reg)
            begin
                low_end_reg <= midpoint_reg;
            end
            else
            begin
                high_end_reg <= midpoint_reg;
            end
            step_count_reg       <= step_count_reg + 7'd1;
            previous_rounded_reg <= current_rounded_reg;
        end
        // Midpoint, then its scaled image, then its rounded image, each registered in turn.
        if (cmd.make_mid)
        begin
            midpoint_reg  <= mid_val;
            img_phase_reg <= 1'b1;
        end
        else
        begin
            img_phase_reg <= 1'b0;
        end
        if (img_phase_reg)
        begin
            scaled_reg  <= 49'(mid_mag) * 49'(ten_power(d_clamp));
            mid_neg_reg <= midpoint_reg[31];
        end
        current_rounded_reg <= img;
        if (cmd.finish)
        begin
            res_status <= cmd.fin_status;
            if (cmd.fin_status == ST_BAD_RANGE)
            begin
                res_root   <= 32'sd0;
                res_scaled <= 33'sd0;
                res_iters  <= 7'd0;
            end
            else
            begin
                res_root   <= midpoint_reg;
                res_scaled <= current_rounded_reg;
                res_iters  <= step_count_reg;
            end
        end
    end
endmodule

FILE: src/cbrf_ctrl.sv
// Controller state machine sequencing evaluations and bisection steps.
module cbrf_ctrl
    import cbrf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output cbrf_cmd_t  cmd,
    input  cbrf_stat_t stat
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_EVLO   = 9'b000000010,
        S_EVHI   = 9'b000000100,
        S_MID    = 9'b000001000,
        S_IMG    = 9'b000010000,
        S_CHECK  = 9'b000100000,
        S_EVMID  = 9'b001000000,
        S_DONE   = 9'b010000000,
        S_OUT    = 9'b100000000
    } cstate_t;

    cstate_t state_reg, state_next;
    logic [1:0] wait_reg, wait_next;
    logic       out_valid_reg, out_valid_next;
    logic       busy_reg, busy_next;

    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        out_valid_next = out_valid_reg;
        busy_next      = busy_reg;
        cmd            = '0;
        cmd.fin_status = ST_CONVERGED;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    cmd.load        = 1'b1;
                    state_next      = S_EVLO;
                    busy_next       = 1'b0;
                end
            end
            S_EVLO:
            begin
                if (!busy_reg)
                begin
                    cmd.eval_start = 1'b1;
                    busy_next      = 1'b1;
                end
                else if (stat.eval_done)
                begin
                    cmd.save_low   = 1'b1;
                    cmd.eval_start = 1'b1;
                    cmd.eval_sel   = 1'b1;
                    state_next     = S_EVHI;
                end
            end
            S_EVHI:
            begin
                if (stat.eval_done)
                begin
                    busy_next     = 1'b0;
                    if (stat.bad_range)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_BAD_RANGE;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MID;
                    end
                end
            end
            S_MID:
            begin
                cmd.make_mid = 1'b1;
                wait_next    = 2'd0;
                state_next   = S_IMG;
            end
            S_IMG:
            begin
                // Image goes scaled, then rounded, then registered.
                wait_next = wait_reg + 2'd1;
                if (wait_reg == 2'd2)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.image_same)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_CONVERGED;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.eval_start = 1'b1;
                    cmd.eval_mid   = 1'b1;
                    state_next     = S_EVMID;
                end
            end
            S_EVMID:
            begin
                if (stat.eval_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.f_zero)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_EXACT_ROOT;
                    state_next     = S_OUT;
                end
                else if (stat.cap_hit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_CAP_HIT;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_MID;
                end
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wait_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            busy_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            busy_reg      <= busy_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
endmodule

FILE: src/cubic_bisection_root_finder.sv
// Top level of the cubic bisection root finder with its APB register file.
//
//   Channel   Direction  Payload
//   in_ch     sink       lower_end, upper_end (signed Q16.16)
//   out_ch    source     status, root_value, root_rounded_scaled, iterations_used
//   APB       slave      decimal_places and four cubic coefficients
//
// Each transfer takes the two end evaluations, then bisection steps. Each step
// is a Horner evaluation on the shared 32x32 multiplier (a start and three
// rounds of two partial products and a saturating add) together with the
// decision, the midpoint and its registered decimal image. An item takes up to
// MAX_STEPS (64 by default) steps. One item is worked at a time; a new transfer
// is taken once the previous result has been taken. Reset is asynchronous and
// active low and restores the coefficients of x^3-4x-9.
module cubic_bisection_root_finder
    import cbrf_pkg::*;
#(
    parameter int MAX_STEPS     = MAX_STEPS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    cbrf_in_if.sink     in_ch,
    cbrf_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [2:0]         decimals_reg;
    logic signed [31:0] c3_reg, c2_reg, c1_reg, c0_reg;
    logic [2:0]         reg_index;
    cbrf_cmd_t          cmd;
    cbrf_stat_t         stat;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];

    // Register writes complete in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decimals_reg <= 3'd0;
            c3_reg       <= 32'sd65536;
            c2_reg       <= 32'sd0;
            c1_reg       <= -32'sd262144;
            c0_reg       <= -32'sd589824;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_index)
                REG_DECIMALS: decimals_reg <= pwdata[2:0];
                REG_CUBIC:    c3_reg       <= pwdata;
                REG_SQUARE:   c2_reg       <= pwdata;
                REG_LINEAR:   c1_reg       <= pwdata;
                REG_CONSTANT: c0_reg       <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DECIMALS: prdata = {29'd0, decimals_reg};
            REG_CUBIC:    prdata = c3_reg;
            REG_SQUARE:   prdata = c2_reg;
            REG_LINEAR:   prdata = c1_reg;
            REG_CONSTANT: prdata = c0_reg;
            default:      prdata = 32'd0;
        endcase
    end

    cbrf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    cbrf_datapath #(
        .MAX_STEPS     (MAX_STEPS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .lower_in   (in_ch.lower_end),
        .upper_in   (in_ch.upper_end),
        .decimals   (decimals_reg),
        .c3         (c3_reg),
        .c2         (c2_reg),
        .c1         (c1_reg),
        .c0         (c0_reg),
        .res_status (out_ch.status),
        .res_root   (out_ch.root_value),
        .res_scaled (out_ch.root_rounded_scaled),
        .res_iters  (out_ch.iterations_used)
    );
endmodule
